// ===== rtl/log8_counter_merge_unit_defines.svh =====
// ----------------------------------------------------------------------------
// log8_counter_merge_unit_defines
// Assertion macros for the log8 counter merge unit checkers.
// ----------------------------------------------------------------------------
`ifndef LOG8_COUNTER_MERGE_UNIT_DEFINES_SVH
`define LOG8_COUNTER_MERGE_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define L8CM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define L8CM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/l8cm_pkg.sv =====
// ----------------------------------------------------------------------------
// l8cm_pkg
// Types, constants and helper functions of the log8 counter merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package l8cm_pkg;

    localparam int CMD_W  = 2;
    localparam int CELL_W = 8;
    localparam int CNT_W  = 35;
    localparam int WORD_W = 32;
    localparam int LEN_W  = 6;
    localparam int EXP_W  = 6;
    localparam int SH_W   = 5;
    localparam int REM_W  = 31;
    localparam int RES_W  = EXP_W + 3;
    localparam int NUM_ST = 9;

    localparam logic [CELL_W-1:0] SMALL_MAX = 8'd16;
    localparam logic [CELL_W-1:0] CODE_MAX  = 8'hFF;

    localparam logic [WORD_W-1:0] MMH_C1 = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] MMH_C2 = 32'h1b873593;
    localparam logic [WORD_W-1:0] MMH_E  = 32'he6546b64;
    localparam logic [WORD_W-1:0] MMH_F1 = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] MMH_F2 = 32'hc2b2ae35;
    localparam logic [WORD_W-1:0] MMH_LEN = 32'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INC_TEST = 2'd0,
        CMD_DECODE   = 2'd1,
        CMD_MERGE    = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             inc;
        logic [CNT_W-1:0] sum;
        logic             small_sum;
        logic [EXP_W-1:0] expo;
        logic [2:0]       top;
        logic [REM_W-1:0] rem;
        logic [SH_W-1:0]  nbits;
    } stage_meta_t;

    function automatic logic [CNT_W-1:0] cell_expand(input logic [CELL_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v <= SMALL_MAX)
            r = CNT_W'(v);
        else
            r = CNT_W'({1'b1, v[2:0]}) << (v[7:3] - 5'd1);
        return r;
    endfunction

    function automatic logic inc_test(input logic [CELL_W-1:0] v,
                                      input logic [WORD_W-1:0] rnd);
        logic [WORD_W-1:0] m;
        m = ~({WORD_W{1'b1}} << (v[7:3] - 5'd1));
        return (v < SMALL_MAX) || ((rnd & m) == '0);
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    function automatic logic [WORD_W-1:0] mmh_round(input logic [WORD_W-1:0] acc,
                                                    input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] a;
        a = rotl(acc ^ k, 13);
        return (a << 2) + a + MMH_E;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/l8cm_if.sv =====
// ----------------------------------------------------------------------------
// l8cm_if
// Valid/ready channels of the log8 counter merge unit: commands and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface l8cm_in_if;
    logic                          valid;
    logic                          ready;
    logic [l8cm_pkg::CMD_W-1:0]    cmd;
    logic [l8cm_pkg::CELL_W-1:0]   value_a;
    logic [l8cm_pkg::CELL_W-1:0]   value_b;
    logic [l8cm_pkg::WORD_W-1:0]   random_word;
    logic [l8cm_pkg::WORD_W-1:0]   hash_seed;

    modport source (output valid, cmd, value_a, value_b, random_word, hash_seed,
                    input ready);
    modport sink (input valid, cmd, value_a, value_b, random_word, hash_seed,
                  output ready);
    modport monitor (input valid, ready, cmd, value_a, value_b, random_word,
                     hash_seed);
endinterface

interface l8cm_out_if;
    logic                          valid;
    logic                          ready;
    logic                          do_increment;
    logic [l8cm_pkg::CNT_W-1:0]    decoded_count;
    logic [l8cm_pkg::CELL_W-1:0]   merged_value;
    logic                          saturated;

    modport source (output valid, do_increment, decoded_count, merged_value, saturated,
                    input ready);
    modport sink (input valid, do_increment, decoded_count, merged_value, saturated,
                  output ready);
    modport monitor (input valid, ready, do_increment, decoded_count, merged_value,
                     saturated);
endinterface

`default_nettype wire

// ===== rtl/log8_counter_merge_unit.sv =====
// ----------------------------------------------------------------------------
// log8_counter_merge_unit
// Increment test, decode and merge of 8-bit logarithmic sketch counter cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch carries one command item (cmd, value_a, value_b, random_word,
//   hash_seed); res_ch returns exactly one result item for each, in order.
//   cmd 0 tests an increment against random_word, cmd 1 decodes value_a,
//   cmd 2 decodes and adds both cells and re-encodes the sum with hashed
//   rounding (saturated marks a clamp at 255). Unused fields read 0.
//   Throughput: one item per cycle while cmd_ch.ready is high. The item
//   passes nine register stages before res_ch.valid rises. The depth is
//   set by the MurmurHash3 chain of the merge rounding, with at most one
//   32x32 multiply on any stage's path.
//   Every stage has its own valid bit and loads whenever it is empty or its
//   successor loads, so a stalled receiver holds the output item and the
//   pipeline keeps taking items until every stage is full. cmd_ch.ready is
//   low only when all stages hold items and res_ch.ready is low.
//   Reset empties the pipeline; no item is lost or repeated on a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module log8_counter_merge_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    l8cm_in_if.sink         cmd_ch,
    l8cm_out_if.source      res_ch
);

    localparam int NS = l8cm_pkg::NUM_ST;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] ld;

    // stage 0: cell expansion and increment test
    logic [l8cm_pkg::CMD_W-1:0]  s0_cmd_reg;
    logic                        s0_inc_reg;
    logic [l8cm_pkg::CNT_W-1:0]  s0_ea_reg;
    logic [l8cm_pkg::CNT_W-1:0]  s0_eb_reg;
    logic [l8cm_pkg::WORD_W-1:0] s0_seed_reg;
    // stage 1: sum
    logic [l8cm_pkg::CMD_W-1:0]  s1_cmd_reg;
    logic                        s1_inc_reg;
    logic [l8cm_pkg::CNT_W-1:0]  s1_sum_reg;
    logic [l8cm_pkg::WORD_W-1:0] s1_seed_reg;
    // stages 2..7
    l8cm_pkg::stage_meta_t       s2_meta_next;
    l8cm_pkg::stage_meta_t       s2_meta_reg, s3_meta_reg, s4_meta_reg;
    l8cm_pkg::stage_meta_t       s5_meta_reg, s6_meta_reg, s7_meta_reg;
    logic [l8cm_pkg::WORD_W-1:0] s2_k0_reg, s2_k1_reg, s2_seed_reg;
    logic [l8cm_pkg::WORD_W-1:0] s3_k0_reg, s3_k1_reg, s3_seed_reg;
    logic [l8cm_pkg::WORD_W-1:0] s4_acc_reg, s4_k1_reg;
    logic [l8cm_pkg::WORD_W-1:0] s5_h_reg, s6_h_reg, s7_h_reg;
    logic [l8cm_pkg::WORD_W-1:0] s5_h_next, s7_h_next;
    // stage 8: output
    logic                        s8_inc_reg;
    logic [l8cm_pkg::CNT_W-1:0]  s8_cnt_reg;
    logic [l8cm_pkg::CELL_W-1:0] s8_code_reg;
    logic                        s8_sat_reg;
    logic [l8cm_pkg::CELL_W-1:0] s8_code_next;
    logic                        s8_sat_next;

    logic [l8cm_pkg::LEN_W-1:0]  sum_len;
    logic [l8cm_pkg::WORD_W-1:0] h_fin;
    logic [l8cm_pkg::REM_W-1:0]  rnd_masked;
    logic [l8cm_pkg::RES_W-1:0]  res_code;
    logic                        is_dec, is_mrg;

    always_comb
    begin
        ld[NS-1] = !vld_reg[NS-1] || res_ch.ready;
        for (int i = NS - 2; i >= 0; i--)
            ld[i] = !vld_reg[i] || ld[i+1];
    end

    assign cmd_ch.ready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (ld[0])
                vld_reg[0] <= cmd_ch.valid;
            for (int i = 1; i < NS; i++)
                if (ld[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign is_dec = (cmd_ch.cmd == l8cm_pkg::CMD_DECODE);
    assign is_mrg = (cmd_ch.cmd == l8cm_pkg::CMD_MERGE);

    // bit length of the sum sets the exponent and the dropped bits
    always_comb
    begin
        sum_len = '0;
        for (int i = 0; i < l8cm_pkg::CNT_W; i++)
            if (s1_sum_reg[i])
                sum_len = l8cm_pkg::LEN_W'(i + 1);
        s2_meta_next.cmd       = s1_cmd_reg;
        s2_meta_next.inc       = s1_inc_reg;
        s2_meta_next.sum       = s1_sum_reg;
        s2_meta_next.small_sum = (s1_sum_reg <= l8cm_pkg::CNT_W'(l8cm_pkg::SMALL_MAX));
        s2_meta_next.nbits     = l8cm_pkg::SH_W'(sum_len - 6'd4);
        s2_meta_next.expo      = l8cm_pkg::EXP_W'(sum_len - 6'd3);
        s2_meta_next.top       = 3'(s1_sum_reg >> s2_meta_next.nbits);
        s2_meta_next.rem       = s1_sum_reg[l8cm_pkg::REM_W-1:0]
                               & ~({l8cm_pkg::REM_W{1'b1}} << s2_meta_next.nbits);
    end

    always_comb
    begin
        s5_h_next = l8cm_pkg::mmh_round(s4_acc_reg, s4_k1_reg) ^ l8cm_pkg::MMH_LEN;
        s5_h_next = s5_h_next ^ (s5_h_next >> 16);
        s7_h_next = s6_h_reg ^ (s6_h_reg >> 13);
    end

    always_comb
    begin
        h_fin        = s7_h_reg ^ (s7_h_reg >> 16);
        rnd_masked   = h_fin[l8cm_pkg::REM_W-1:0]
                     & ~({l8cm_pkg::REM_W{1'b1}} << s7_meta_reg.nbits);
        res_code     = {s7_meta_reg.expo, s7_meta_reg.top}
                     + l8cm_pkg::RES_W'(rnd_masked < s7_meta_reg.rem);
        s8_code_next = '0;
        s8_sat_next  = 1'b0;
        if (s7_meta_reg.cmd == l8cm_pkg::CMD_MERGE)
        begin
            if (s7_meta_reg.small_sum)
                s8_code_next = s7_meta_reg.sum[l8cm_pkg::CELL_W-1:0];
            else if (res_code[l8cm_pkg::RES_W-1])
            begin
                s8_code_next = l8cm_pkg::CODE_MAX;
                s8_sat_next  = 1'b1;
            end
            else
                s8_code_next = res_code[l8cm_pkg::CELL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s0_cmd_reg  <= cmd_ch.cmd;
            s0_inc_reg  <= (cmd_ch.cmd == l8cm_pkg::CMD_INC_TEST)
                           && l8cm_pkg::inc_test(cmd_ch.value_a, cmd_ch.random_word);
            s0_ea_reg   <= (is_dec || is_mrg) ? l8cm_pkg::cell_expand(cmd_ch.value_a) : '0;
            s0_eb_reg   <= is_mrg ? l8cm_pkg::cell_expand(cmd_ch.value_b) : '0;
            s0_seed_reg <= cmd_ch.hash_seed;
        end
        if (ld[1])
        begin
            s1_cmd_reg  <= s0_cmd_reg;
            s1_inc_reg  <= s0_inc_reg;
            s1_sum_reg  <= s0_ea_reg + s0_eb_reg;
            s1_seed_reg <= s0_seed_reg;
        end
        if (ld[2])
        begin
            s2_meta_reg <= s2_meta_next;
            s2_k0_reg   <= s1_sum_reg[l8cm_pkg::WORD_W-1:0] * l8cm_pkg::MMH_C1;
            s2_k1_reg   <= l8cm_pkg::WORD_W'(s1_sum_reg[l8cm_pkg::CNT_W-1:l8cm_pkg::WORD_W])
                           * l8cm_pkg::MMH_C1;
            s2_seed_reg <= s1_seed_reg;
        end
        if (ld[3])
        begin
            s3_meta_reg <= s2_meta_reg;
            s3_k0_reg   <= l8cm_pkg::rotl(s2_k0_reg, 15) * l8cm_pkg::MMH_C2;
            s3_k1_reg   <= l8cm_pkg::rotl(s2_k1_reg, 15) * l8cm_pkg::MMH_C2;
            s3_seed_reg <= s2_seed_reg;
        end
        if (ld[4])
        begin
            s4_meta_reg <= s3_meta_reg;
            s4_acc_reg  <= l8cm_pkg::mmh_round(s3_seed_reg, s3_k0_reg);
            s4_k1_reg   <= s3_k1_reg;
        end
        if (ld[5])
        begin
            s5_meta_reg <= s4_meta_reg;
            s5_h_reg    <= s5_h_next;
        end
        if (ld[6])
        begin
            s6_meta_reg <= s5_meta_reg;
            s6_h_reg    <= s5_h_reg * l8cm_pkg::MMH_F1;
        end
        if (ld[7])
        begin
            s7_meta_reg <= s6_meta_reg;
            s7_h_reg    <= s7_h_next * l8cm_pkg::MMH_F2;
        end
        if (ld[8])
        begin
            s8_inc_reg  <= s7_meta_reg.inc;
            s8_cnt_reg  <= s7_meta_reg.sum;
            s8_code_reg <= s8_code_next;
            s8_sat_reg  <= s8_sat_next;
        end
    end

    assign res_ch.valid         = vld_reg[NS-1];
    assign res_ch.do_increment  = s8_inc_reg;
    assign res_ch.decoded_count = s8_cnt_reg;
    assign res_ch.merged_value  = s8_code_reg;
    assign res_ch.saturated     = s8_sat_reg;

endmodule

`default_nettype wire

// ===== rtl/l8cm_checker.sv =====
// ----------------------------------------------------------------------------
// l8cm_checker
// Port-level assertions on the result channel of the log8 counter merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "log8_counter_merge_unit_defines.svh"

module l8cm_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         res_valid,
    input  wire logic                         res_ready,
    input  wire logic                         res_inc,
    input  wire logic [l8cm_pkg::CNT_W-1:0]  res_cnt,
    input  wire logic [l8cm_pkg::CELL_W-1:0] res_code,
    input  wire logic                         res_sat
);

    `L8CM_ASSERT_NXT(a_res_hold, res_valid && !res_ready,
        res_valid && $stable(res_inc) && $stable(res_cnt) && $stable(res_code)
        && $stable(res_sat), "result item changed while stalled")

    `L8CM_ASSERT_IMP(a_inc_only, res_valid && res_inc,
        res_cnt == '0 && res_code == '0 && !res_sat, "increment result carries other fields")

    `L8CM_ASSERT_IMP(a_sat_clamp, res_valid && res_sat,
        res_code == l8cm_pkg::CODE_MAX && res_cnt != '0, "saturated without clamped code")

    `L8CM_ASSERT_IMP(a_zero_sum, res_valid && res_cnt == '0,
        res_code == '0 && !res_sat, "merged code from a zero count")

endmodule

bind log8_counter_merge_unit l8cm_checker u_l8cm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_ch.valid),
    .res_ready (res_ch.ready),
    .res_inc   (res_ch.do_increment),
    .res_cnt   (res_ch.decoded_count),
    .res_code  (res_ch.merged_value),
    .res_sat   (res_ch.saturated)
);

`default_nettype wire
